// ===== sv/tgpf_pkg.sv =====
// ---------------------------------------------------------------------------
// tgpf_pkg
// Shared types and constants of the tension guarded position follower.
// ---------------------------------------------------------------------------
package tgpf_pkg;

   // field widths
   localparam int POS_W    = 21;
   localparam int TEN_W    = 16;
   localparam int SUM_W    = 23;
   // baseline keeps the full sum width, limit adds the margin on top
   localparam int LIMIT_W  = 24;
   localparam int OUT_W    = 32;
   localparam int GAIN_W   = 10;
   localparam int MARGIN_W = 15;
   localparam int COUNT_W  = 7;
   localparam int CHSEL_W  = 2;
   localparam int CMD_W    = 2;

   // input channel packing
   localparam int IN_CHANNELS = 4;
   localparam int REQ_DATA_W  = 112;
   localparam int RSP_DATA_W  = 64;

   // configuration port
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 15;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;

   // lanes of the baseline divider (master, slave)
   localparam int DIV_LANES = 2;
   localparam int LANE_M    = 0;
   localparam int LANE_S    = 1;

   // command codes on req_tuser
   localparam logic [CMD_W-1:0] CMD_POSITION = 2'd0;
   localparam logic [CMD_W-1:0] CMD_TENSION  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK     = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PULL_GAIN      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BAND_MARGIN    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_AVERAGE_COUNT  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MASTER_CHANNEL = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_CHANNEL  = 3'd4;

   typedef enum logic [1:0] {
      KIND_POSITION,
      KIND_TENSION,
      KIND_TICK
   } item_kind_type;

   // classified item handed from front to back
   typedef struct packed {
      item_kind_type            kind;
      logic signed [POS_W-1:0]  pos_m;
      logic signed [POS_W-1:0]  pos_s;
      logic signed [TEN_W-1:0]  ten_m;
      logic signed [TEN_W-1:0]  ten_s;
   } item_type;

   typedef struct packed {
      logic [GAIN_W-1:0]   pull_gain;
      logic [MARGIN_W-1:0] band_margin;
      logic [COUNT_W-1:0]  average_count;
      logic [CHSEL_W-1:0]  master_channel;
      logic [CHSEL_W-1:0]  slave_channel;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DIFF,
      ST_MUL,
      ST_ADD
   } back_state_type;

endpackage

// ===== sv/tgpf_front.sv =====
// ---------------------------------------------------------------------------
// tgpf_front
// Accepts request beats, drops unknown commands, picks the master and slave
// tension channels and pushes one classified item into the queue.
// ---------------------------------------------------------------------------
module tgpf_front
   import tgpf_pkg::*;
#(
   parameter int TENSION_CHANNELS = 4
) (
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [CMD_W-1:0]      req_tuser,
   input  cfg_type               cfg,
   input  logic                  q_full,
   output logic                  q_push,
   output item_type              q_item
);

   logic signed [TEN_W-1:0] chan [IN_CHANNELS];
   logic                    beat;

   // unpack the four tension channels
   always_comb begin
      for (int i = 0; i < IN_CHANNELS; i++) begin
         chan[i] = req_tdata[2*POS_W + i*TEN_W +: TEN_W];
      end
   end

   assign req_tready = !q_full;
   assign beat       = req_tvalid && req_tready;

   // classify the beat; channels the block does not have read zero
   always_comb begin
      q_item.pos_m = req_tdata[POS_W-1:0];
      q_item.pos_s = req_tdata[2*POS_W-1:POS_W];
      q_item.ten_m = (int'(cfg.master_channel) < TENSION_CHANNELS) ?
                     chan[cfg.master_channel] : '0;
      q_item.ten_s = (int'(cfg.slave_channel) < TENSION_CHANNELS) ?
                     chan[cfg.slave_channel] : '0;
      q_item.kind  = KIND_TICK;
      q_push       = 1'b0;
      unique case (req_tuser)
         CMD_POSITION: begin
            q_item.kind = KIND_POSITION;
            q_push      = beat;
         end
         CMD_TENSION: begin
            q_item.kind = KIND_TENSION;
            q_push      = beat;
         end
         CMD_TICK: begin
            q_item.kind = KIND_TICK;
            q_push      = beat;
         end
         default: begin
            q_push = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/tgpf_queue.sv =====
// ---------------------------------------------------------------------------
// tgpf_queue
// Short register queue between the front and the back.
// ---------------------------------------------------------------------------
module tgpf_queue
   import tgpf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output logic     valid,
   output item_type pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   item_type           entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full     = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign valid    = (count_ff != '0);
   assign pop_item = entry_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== sv/tgpf_divider.sv =====
// ---------------------------------------------------------------------------
// tgpf_divider
// Two-lane restoring divider for the tension baselines: signed sum over a
// small unsigned count, truncating toward zero, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module tgpf_divider
   import tgpf_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [SUM_W-1:0]  dividend [DIV_LANES],
   input  logic [COUNT_W-1:0]       divisor,
   output logic                     done,
   output logic signed [SUM_W-1:0]  quotient [DIV_LANES]
);

   localparam int STEP_W = $clog2(SUM_W);

   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [COUNT_W-1:0] divisor_ff, divisor_in;
   logic [SUM_W-1:0]   mag_ff [DIV_LANES];
   logic [SUM_W-1:0]   mag_in [DIV_LANES];
   logic [COUNT_W-1:0] rem_ff [DIV_LANES];
   logic [COUNT_W-1:0] rem_in [DIV_LANES];
   logic               neg_ff [DIV_LANES];
   logic               neg_in [DIV_LANES];
   logic [COUNT_W:0]   trial  [DIV_LANES];
   logic [SUM_W-1:0]   signed_q [DIV_LANES];

   // one shift-subtract step per lane
   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      step_in    = step_ff;
      divisor_in = divisor_ff;
      for (int l = 0; l < DIV_LANES; l++) begin
         mag_in[l] = mag_ff[l];
         rem_in[l] = rem_ff[l];
         neg_in[l] = neg_ff[l];
         trial[l]  = {rem_ff[l], mag_ff[l][SUM_W-1]};
      end
      if (start) begin
         busy_in    = 1'b1;
         step_in    = '0;
         divisor_in = divisor;
         for (int l = 0; l < DIV_LANES; l++) begin
            neg_in[l] = dividend[l][SUM_W-1];
            mag_in[l] = dividend[l][SUM_W-1] ? SUM_W'(-dividend[l]) : SUM_W'(dividend[l]);
            rem_in[l] = '0;
         end
      end else if (busy_ff) begin
         for (int l = 0; l < DIV_LANES; l++) begin
            if (trial[l] >= {1'b0, divisor_ff}) begin
               rem_in[l] = COUNT_W'(trial[l] - {1'b0, divisor_ff});
               mag_in[l] = {mag_ff[l][SUM_W-2:0], 1'b1};
            end else begin
               rem_in[l] = COUNT_W'(trial[l]);
               mag_in[l] = {mag_ff[l][SUM_W-2:0], 1'b0};
            end
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      divisor_ff <= divisor_in;
      for (int l = 0; l < DIV_LANES; l++) begin
         mag_ff[l] <= mag_in[l];
         rem_ff[l] <= rem_in[l];
         neg_ff[l] <= neg_in[l];
      end
   end

   // restore the sign; a count lowered below the samples taken can leave
   // a quotient as wide as the sum itself
   always_comb begin
      for (int l = 0; l < DIV_LANES; l++) begin
         signed_q[l] = neg_ff[l] ? SUM_W'(-mag_ff[l]) : mag_ff[l];
         quotient[l] = signed_q[l];
      end
   end

   assign done = done_ff;

endmodule

// ===== sv/tgpf_back.sv =====
// ---------------------------------------------------------------------------
// tgpf_back
// Executes queued items: keeps positions and tensions, builds the baselines
// through the divider and turns each tick into a master and slave command.
// ---------------------------------------------------------------------------
module tgpf_back
   import tgpf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int DM_W   = LIMIT_W + 1;
   localparam int DS_W   = SUM_W + 1;
   localparam int PM_W   = GAIN_W + 1 + DM_W;
   localparam int PS_W   = GAIN_W + 1 + DS_W;
   localparam int ACC_W  = PM_W + 1;

   back_state_type state_ff, state_in;

   logic signed [POS_W-1:0]   last_m_ff, last_m_in, last_s_ff, last_s_in;
   logic signed [POS_W-1:0]   home_m_ff, home_m_in, home_s_ff, home_s_in;
   logic signed [TEN_W-1:0]   lt_m_ff, lt_m_in, lt_s_ff, lt_s_in;
   logic signed [SUM_W-1:0]   base_m_ff, base_m_in, base_s_ff, base_s_in;
   logic signed [LIMIT_W-1:0] limit_ff, limit_in;
   logic signed [SUM_W-1:0]   sum_m_ff, sum_m_in, sum_s_ff, sum_s_in;
   logic [COUNT_W-1:0]        samples_ff, samples_in;
   logic                      pos_ready_ff, pos_ready_in;
   logic                      ten_ready_ff, ten_ready_in;

   logic signed [DM_W-1:0]    dm_ff, dm_in;
   logic signed [DS_W-1:0]    ds_ff, ds_in;
   logic                      s_pull_ff, s_pull_in;
   logic signed [SUM_W-1:0]   follow_ff, follow_in;
   logic signed [PM_W-1:0]    prod_m_ff, prod_m_in;
   logic signed [PS_W-1:0]    prod_s_ff, prod_s_in;
   logic signed [OUT_W-1:0]   cmd_m_ff, cmd_m_in, cmd_s_ff, cmd_s_in;
   logic                      rsp_valid_ff;

   logic [COUNT_W-1:0]        count_eff;
   logic [COUNT_W-1:0]        samples_next;
   logic signed [SUM_W-1:0]   sum_m_next, sum_s_next;
   logic                      avg_full;
   logic                      is_tension, is_tick, ticks_ready;
   logic                      div_start, div_done, load_out;
   logic signed [SUM_W-1:0]   div_dividend [DIV_LANES];
   logic signed [SUM_W-1:0]   div_quot [DIV_LANES];
   logic signed [GAIN_W:0]    gain_s;

   // clamp a wide sum to the 32-bit signed command range
   function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [ACC_W-1:0] v);
      if (v[ACC_W-1:OUT_W-1] == '0 || v[ACC_W-1:OUT_W-1] == '1) begin
         return v[OUT_W-1:0];
      end
      return v[ACC_W-1] ? {1'b1, {(OUT_W-1){1'b0}}} : {1'b0, {(OUT_W-1){1'b1}}};
   endfunction

   // averaging bookkeeping for the item at the queue head
   assign count_eff    = (cfg.average_count == '0) ? COUNT_W'(1) : cfg.average_count;
   assign samples_next = samples_ff + 1'b1;
   assign sum_m_next   = sum_m_ff + SUM_W'(q_item.ten_m);
   assign sum_s_next   = sum_s_ff + SUM_W'(q_item.ten_s);
   assign avg_full     = (samples_next >= count_eff);
   assign is_tension   = q_valid && (q_item.kind == KIND_TENSION);
   assign is_tick      = q_valid && (q_item.kind == KIND_TICK);
   assign ticks_ready  = pos_ready_ff && ten_ready_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (is_tension && !ten_ready_ff && avg_full) begin
               state_in = ST_DIVIDE;
            end else if (is_tick && ticks_ready) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIFF: state_in = ST_MUL;
         ST_MUL:  state_in = ST_ADD;
         ST_ADD: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop     = 1'b0;
      div_start = 1'b0;
      load_out  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            q_pop     = q_valid;
            div_start = is_tension && !ten_ready_ff && avg_full;
         end
         ST_ADD: begin
            load_out = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // position and tension state
   always_comb begin
      last_m_in    = last_m_ff;
      last_s_in    = last_s_ff;
      home_m_in    = home_m_ff;
      home_s_in    = home_s_ff;
      lt_m_in      = lt_m_ff;
      lt_s_in      = lt_s_ff;
      base_m_in    = base_m_ff;
      base_s_in    = base_s_ff;
      limit_in     = limit_ff;
      sum_m_in     = sum_m_ff;
      sum_s_in     = sum_s_ff;
      samples_in   = samples_ff;
      pos_ready_in = pos_ready_ff;
      ten_ready_in = ten_ready_ff;
      if (q_pop && (q_item.kind == KIND_POSITION)) begin
         last_m_in = q_item.pos_m;
         last_s_in = q_item.pos_s;
         if (!pos_ready_ff) begin
            home_m_in    = q_item.pos_m;
            home_s_in    = q_item.pos_s;
            pos_ready_in = 1'b1;
         end
      end
      if (q_pop && is_tension) begin
         lt_m_in = q_item.ten_m;
         lt_s_in = q_item.ten_s;
         if (!ten_ready_ff) begin
            sum_m_in   = sum_m_next;
            sum_s_in   = sum_s_next;
            samples_in = samples_next;
         end
      end
      if (div_done && (state_ff == ST_DIVIDE)) begin
         base_m_in    = div_quot[LANE_M];
         base_s_in    = div_quot[LANE_S];
         limit_in     = LIMIT_W'(div_quot[LANE_M])
                        + $signed({{(LIMIT_W-MARGIN_W){1'b0}}, cfg.band_margin});
         ten_ready_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_m_ff     <= '0;
         sum_s_ff     <= '0;
         samples_ff   <= '0;
         pos_ready_ff <= 1'b0;
         ten_ready_ff <= 1'b0;
      end else begin
         sum_m_ff     <= sum_m_in;
         sum_s_ff     <= sum_s_in;
         samples_ff   <= samples_in;
         pos_ready_ff <= pos_ready_in;
         ten_ready_ff <= ten_ready_in;
      end
   end

   always_ff @(posedge clock) begin
      last_m_ff <= last_m_in;
      last_s_ff <= last_s_in;
      home_m_ff <= home_m_in;
      home_s_ff <= home_s_in;
      lt_m_ff   <= lt_m_in;
      lt_s_ff   <= lt_s_in;
      base_m_ff <= base_m_in;
      base_s_ff <= base_s_in;
      limit_ff  <= limit_in;
   end

   // baseline divider, fed with the sums including the closing sample
   assign div_dividend[LANE_M] = sum_m_next;
   assign div_dividend[LANE_S] = sum_s_next;

   tgpf_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (count_eff),
      .done     (div_done),
      .quotient (div_quot)
   );

   // tick: tension errors, then products, then final sums
   assign gain_s = $signed({1'b0, cfg.pull_gain});

   always_comb begin
      ds_in     = DS_W'(lt_s_ff) - DS_W'(base_s_ff);
      s_pull_in = (lt_s_ff < base_s_ff);
      follow_in = SUM_W'(last_m_ff) - SUM_W'(home_m_ff) + SUM_W'(home_s_ff);
      if (lt_m_ff < base_m_ff) begin
         dm_in = DM_W'(lt_m_ff) - DM_W'(base_m_ff);
      end else if (LIMIT_W'(lt_m_ff) > limit_ff) begin
         dm_in = DM_W'(lt_m_ff) - DM_W'(limit_ff);
      end else begin
         dm_in = '0;
      end
      prod_m_in = gain_s * dm_ff;
      prod_s_in = gain_s * ds_ff;
      // a wide baseline can push the pull terms past 32 bits
      cmd_m_in  = clamp_out(ACC_W'(last_m_ff) + ACC_W'(prod_m_ff));
      cmd_s_in  = s_pull_ff ? clamp_out(ACC_W'(last_s_ff) + ACC_W'(prod_s_ff))
                            : OUT_W'(follow_ff);
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DIFF) begin
         dm_ff     <= dm_in;
         ds_ff     <= ds_in;
         s_pull_ff <= s_pull_in;
         follow_ff <= follow_in;
      end
      if (state_ff == ST_MUL) begin
         prod_m_ff <= prod_m_in;
         prod_s_ff <= prod_s_in;
      end
      if (load_out) begin
         cmd_m_ff <= cmd_m_in;
         cmd_s_ff <= cmd_s_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {cmd_s_ff, cmd_m_ff};

   // once the baseline is taken it stays
   assert property (@(posedge clock) disable iff (reset)
      ten_ready_ff |=> ten_ready_ff)
      else $error("tension ready dropped");

   // the divider only runs before the baseline exists
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> !ten_ready_ff)
      else $error("divide while tension already ready");

   // the queue is drained only between items
   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE))
      else $error("queue pop outside idle");

   // a finished tick always reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADD) && !rsp_valid_ff |=> rsp_valid_ff)
      else $error("tick result lost");

   // a tick only runs when positions and tensions are known
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIFF) |-> (pos_ready_ff && ten_ready_ff))
      else $error("tick processed before ready");

endmodule

// ===== sv/tension_guarded_position_follower_core.sv =====
// ---------------------------------------------------------------------------
// tension_guarded_position_follower_core
// Follows master motor position on the slave side and pulls back or
// releases when the selected tension channels leave their baseline band.
//
// channel  direction  fields (lowest bit first)
// req_     in         tuser: cmd; tdata: position_master, position_slave,
//                     tension_ch0, tension_ch1, tension_ch2, tension_ch3
// rsp_     out        tdata: command_master, command_slave
// csr_     in         write enable, register index, write data
//
// Position and tension beats are taken in the idle state; the tension beat that
// completes the average also waits on the 23-step divider for both baselines.
// A tick steps through pop, difference, multiply and add into the output
// register; it holds in add while a previous result waits on the response side.
// A two-entry queue lets the request side keep accepting while the back end
// works or the response side stalls. Reset is synchronous and clears control
// state and the registers back to their documented defaults.
// ---------------------------------------------------------------------------
module tension_guarded_position_follower_core
   import tgpf_pkg::*;
#(
   parameter int TENSION_CHANNELS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // position_master, position_slave, tension_ch0..tension_ch3, zero fill
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // cmd
   input  logic [CMD_W-1:0]       req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // command_master, command_slave
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_full, q_push, q_pop, q_valid;
   item_type push_item, head_item;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_PULL_GAIN:      cfg_in.pull_gain      = csr_wdata[GAIN_W-1:0];
            CSR_BAND_MARGIN:    cfg_in.band_margin    = csr_wdata[MARGIN_W-1:0];
            CSR_AVERAGE_COUNT:  cfg_in.average_count  = csr_wdata[COUNT_W-1:0];
            CSR_MASTER_CHANNEL: cfg_in.master_channel = csr_wdata[CHSEL_W-1:0];
            CSR_SLAVE_CHANNEL:  cfg_in.slave_channel  = csr_wdata[CHSEL_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pull_gain      <= GAIN_W'(10);
         cfg_ff.band_margin    <= MARGIN_W'(30);
         cfg_ff.average_count  <= COUNT_W'(5);
         cfg_ff.master_channel <= CHSEL_W'(0);
         cfg_ff.slave_channel  <= CHSEL_W'(2);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: accept and classify
   tgpf_front #(
      .TENSION_CHANNELS (TENSION_CHANNELS)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   // queue between front and back
   tgpf_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .pop       (q_pop),
      .valid     (q_valid),
      .pop_item  (head_item)
   );

   // back: execute items and drive results
   tgpf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (head_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== tb/sv/tension_guarded_position_follower_core_test.sv =====
// ---------------------------------------------------------------------------
// tension_guarded_position_follower_core_test
// Self-checking bench for the tension guarded position follower. A queue of
// position, tension, tick and unknown beats feeds the request stream. Every
// accepted beat is run through a local prediction of the follower, and each
// command pair on the response stream is compared with the oldest predicted
// pair. Register settings and idling patterns change between drained phases.
// ---------------------------------------------------------------------------
module tension_guarded_position_follower_core_test;
   import tgpf_pkg::*;

   localparam int CHANNELS = 4;
   localparam int DRAIN_CYCLES = 64;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_BEATS = 412;
   localparam int MAX_REPORTS = 10;
   localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
   localparam longint POS_MAX = 1048575;
   localparam longint POS_MIN = -1048576;
   localparam longint TEN_MAX = 32767;
   localparam longint TEN_MIN = -32768;
   localparam longint OUT_MAX = 64'sd2147483647;
   localparam longint OUT_MIN = -64'sd2147483648;

   typedef struct packed {
      logic [CMD_W-1:0]                  cmd;
      logic [CHANNELS-1:0][TEN_W-1:0]    ten;
      logic signed [POS_W-1:0]           pos_s;
      logic signed [POS_W-1:0]           pos_m;
   } req_item_t;

   typedef struct packed {
      logic signed [OUT_W-1:0] slave;
      logic signed [OUT_W-1:0] master;
   } cmd_pair_t;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // position_master, position_slave, tension_ch0..tension_ch3, zero fill
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   // cmd
   logic [CMD_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // command_master, command_slave
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // register copy
   logic [GAIN_W-1:0]   pull_gain = 10;
   logic [MARGIN_W-1:0] band_margin = 30;
   logic [COUNT_W-1:0]  average_count = 5;
   logic [CHSEL_W-1:0]  master_channel = 0;
   logic [CHSEL_W-1:0]  slave_channel = 2;

   // follower state
   logic signed [POS_W-1:0]   home_m = '0, home_s = '0, last_m = '0, last_s = '0;
   logic signed [TEN_W-1:0]   ten_m = '0, ten_s = '0;
   logic signed [SUM_W-1:0]   base_m = '0, base_s = '0;
   logic signed [LIMIT_W-1:0] upper_limit = '0;
   logic signed [SUM_W-1:0]   sum_m = '0, sum_s = '0;
   logic [COUNT_W-1:0]        samples_taken = '0;
   bit                        position_ready = 0, tension_ready = 0;

   req_item_t pending_beats[$];
   cmd_pair_t expected_cmds[$];
   req_item_t req_item;
   cmd_pair_t predicted;
   cmd_pair_t expected_pair;
   cmd_pair_t actual;
   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int mismatches = 0;
   int beats_sent = 0;
   int cmds_checked = 0;
   int reg_writes = 0;
   int quiet_cycles = 0;

   tension_guarded_position_follower_core #(
      .TENSION_CHANNELS(CHANNELS)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [OUT_W-1:0] saturate(input longint v);
      if (v > OUT_MAX) return OUT_MAX[OUT_W-1:0];
      if (v < OUT_MIN) return OUT_MIN[OUT_W-1:0];
      return v[OUT_W-1:0];
   endfunction

   // a selector past the last channel reads zero
   function automatic logic signed [TEN_W-1:0] pick_tension(input req_item_t it,
                                                            input logic [CHSEL_W-1:0] ch);
      if (ch >= CHANNELS) return '0;
      return it.ten[ch];
   endfunction

   // update follower state for one beat; returns 1 when a command pair results
   function automatic bit follow_beat(input req_item_t it, output cmd_pair_t cmds);
      longint cnt, gain, cm, cs;
      cmds = '0;
      if (it.cmd == CMD_POSITION) begin
         last_m = it.pos_m;
         last_s = it.pos_s;
         if (!position_ready) begin
            home_m = it.pos_m;
            home_s = it.pos_s;
            position_ready = 1;
         end
         return 0;
      end
      if (it.cmd == CMD_TENSION) begin
         ten_m = pick_tension(it, master_channel);
         ten_s = pick_tension(it, slave_channel);
         if (!tension_ready) begin
            // a zero count averages over one sample
            cnt = (average_count == 0) ? 1 : longint'(average_count);
            sum_m = sum_m + ten_m;
            sum_s = sum_s + ten_s;
            samples_taken = samples_taken + 1'b1;
            if (longint'(samples_taken) >= cnt) begin
               base_m = SUM_W'(longint'(sum_m) / cnt);
               base_s = SUM_W'(longint'(sum_s) / cnt);
               upper_limit = LIMIT_W'(longint'(base_m) + longint'(band_margin));
               tension_ready = 1;
            end
         end
         return 0;
      end
      if (it.cmd != CMD_TICK || !position_ready || !tension_ready) return 0;
      gain = longint'(pull_gain);
      if (ten_s < base_s)
         cs = longint'(last_s) + gain * (longint'(ten_s) - longint'(base_s));
      else
         cs = longint'(last_m) - longint'(home_m) + longint'(home_s);
      if (ten_m < base_m)
         cm = longint'(last_m) + gain * (longint'(ten_m) - longint'(base_m));
      else if (ten_m > upper_limit)
         cm = longint'(last_m) + gain * (longint'(ten_m) - longint'(upper_limit));
      else
         cm = longint'(last_m);
      cmds.master = saturate(cm);
      cmds.slave = saturate(cs);
      return 1;
   endfunction

   function automatic logic signed [TEN_W-1:0] clamp_tension(input longint v);
      if (v > TEN_MAX) return TEN_MAX[TEN_W-1:0];
      if (v < TEN_MIN) return TEN_MIN[TEN_W-1:0];
      return v[TEN_W-1:0];
   endfunction

   function automatic longint near(input longint center, input int spread);
      return center + longint'($urandom_range(0, 2 * spread)) - spread;
   endfunction

   // beat with random payload and the given command
   function automatic req_item_t noise_beat(input logic [CMD_W-1:0] cmd);
      req_item_t it;
      it.cmd = cmd;
      it.ten = {$urandom, $urandom};
      it.pos_m = POS_W'($urandom);
      it.pos_s = POS_W'($urandom);
      return it;
   endfunction

   function automatic req_item_t position_beat(input longint pm, input longint ps);
      req_item_t it;
      it = noise_beat(CMD_POSITION);
      it.pos_m = pm[POS_W-1:0];
      it.pos_s = ps[POS_W-1:0];
      return it;
   endfunction

   // selected channels carry the given values, the others random
   function automatic req_item_t tension_beat(input longint tm, input longint ts);
      req_item_t it;
      it = noise_beat(CMD_TENSION);
      it.ten[master_channel] = clamp_tension(tm);
      it.ten[slave_channel] = clamp_tension(ts);
      return it;
   endfunction

   function automatic longint random_position();
      logic signed [POS_W-1:0] p;
      p = POS_W'($urandom);
      case ($urandom_range(0, 9))
         0: return POS_MAX;
         1: return POS_MIN;
         default: return longint'(p);
      endcase
   endfunction

   // master tension near the band edges half of the time, else inside the band or random
   function automatic longint random_master_tension();
      logic signed [TEN_W-1:0] t;
      t = TEN_W'($urandom);
      case ($urandom_range(0, 3))
         0: return longint'(t);
         1: return near(base_m, 3);
         2: return near(upper_limit, 3);
         default: return longint'(base_m) + $urandom_range(0, band_margin);
      endcase
   endfunction

   function automatic longint random_slave_tension();
      logic signed [TEN_W-1:0] t;
      t = TEN_W'($urandom);
      if ($urandom_range(0, 2) == 0) return longint'(t);
      return near(base_s, 3);
   endfunction

   function automatic req_item_t random_beat();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 3) return noise_beat(CMD_UNKNOWN);
      if (roll < 28) return position_beat(random_position(), random_position());
      if (roll < 58) return tension_beat(random_master_tension(), random_slave_tension());
      return noise_beat(CMD_TICK);
   endfunction

   // append one beat to the driver queue
   task automatic enqueue_beat(input req_item_t it);
      pending_beats = {pending_beats, it};
   endtask

   // one register write, block idle
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input int unsigned val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      case (idx)
         CSR_PULL_GAIN:      pull_gain = val[GAIN_W-1:0];
         CSR_BAND_MARGIN:    band_margin = val[MARGIN_W-1:0];
         CSR_AVERAGE_COUNT:  average_count = val[COUNT_W-1:0];
         CSR_MASTER_CHANNEL: master_channel = val[CHSEL_W-1:0];
         CSR_SLAVE_CHANNEL:  slave_channel = val[CHSEL_W-1:0];
         default: ;
      endcase
      reg_writes++;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic program_regs(input int unsigned gain, input int unsigned margin,
                               input int unsigned cnt, input int unsigned mch,
                               input int unsigned sch);
      write_reg(CSR_PULL_GAIN, gain);
      write_reg(CSR_BAND_MARGIN, margin);
      write_reg(CSR_AVERAGE_COUNT, cnt);
      write_reg(CSR_MASTER_CHANNEL, mch);
      write_reg(CSR_SLAVE_CHANNEL, sch);
   endtask

   // wait until every beat is taken and every command pair has come back
   task automatic drain();
      while (pending_beats.size() != 0 || req_tvalid || expected_cmds.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_random_phase(input int send_pct, input int stall_pct);
      send_idle_pct = send_pct;
      rsp_stall_pct = stall_pct;
      repeat (PHASE_BEATS) enqueue_beat(random_beat());
      drain();
   endtask

   // request driver, prediction on every accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            beats_sent++;
            if (follow_beat(req_item, predicted)) expected_cmds = {expected_cmds, predicted};
         end
         if (!req_tvalid || req_tready) begin
            if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_item = pending_beats.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= REQ_DATA_W'({req_item.ten, req_item.pos_s, req_item.pos_m});
               req_tuser <= req_item.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            actual = rsp_tdata;
            cmds_checked++;
            if (expected_cmds.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: unexpected command beat master %0d slave %0d",
                           $time, actual.master, actual.slave);
            end else begin
               expected_pair = expected_cmds.pop_front();
               if (actual.master !== expected_pair.master ||
                   actual.slave !== expected_pair.slave) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS)
                     $display("%0t: command mismatch master exp %0d got %0d, slave exp %0d got %0d",
                              $time, expected_pair.master, actual.master,
                              expected_pair.slave, actual.slave);
               end
            end
         end
         rsp_tready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // watchdog on cycles without any beat moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // averaging window opened wide, gain and margin at their defaults
      write_reg(CSR_AVERAGE_COUNT, 64);
      write_reg(CSR_MASTER_CHANNEL, 1);
      write_reg(CSR_SLAVE_CHANNEL, 3);

      // ticks before ready, unknown command, partial averaging, home latch
      enqueue_beat(noise_beat(CMD_TICK));
      enqueue_beat(noise_beat(CMD_UNKNOWN));
      repeat (3)
         enqueue_beat(tension_beat(longint'($urandom_range(0, 16000)) - 8000,
                                   longint'($urandom_range(0, 16000)) - 8000));
      enqueue_beat(noise_beat(CMD_TICK));
      enqueue_beat(position_beat(POS_MAX, POS_MIN));
      enqueue_beat(noise_beat(CMD_TICK));
      drain();

      // count lowered to zero or three, at or below the samples already taken
      write_reg(CSR_AVERAGE_COUNT, ($urandom_range(0, 1) == 0) ? 0 : 3);
      enqueue_beat(tension_beat(longint'($urandom_range(0, 16000)) - 8000,
                                longint'($urandom_range(0, 16000)) - 8000));
      drain();

      // band edges and field extremes once the baseline is known
      enqueue_beat(position_beat(POS_MIN, POS_MAX));
      enqueue_beat(noise_beat(CMD_TICK));
      enqueue_beat(tension_beat(longint'(base_m) - 1, longint'(base_s) - 1));
      enqueue_beat(noise_beat(CMD_TICK));
      enqueue_beat(tension_beat(longint'(upper_limit) + 1, base_s));
      enqueue_beat(noise_beat(CMD_TICK));
      enqueue_beat(tension_beat(upper_limit, longint'(base_s) + 1));
      enqueue_beat(noise_beat(CMD_TICK));
      enqueue_beat(tension_beat(TEN_MIN, TEN_MIN));
      enqueue_beat(noise_beat(CMD_TICK));
      enqueue_beat(tension_beat(TEN_MAX, TEN_MAX));
      enqueue_beat(noise_beat(CMD_TICK));
      enqueue_beat(noise_beat(CMD_UNKNOWN));
      enqueue_beat(position_beat(0, 0));
      enqueue_beat(noise_beat(CMD_TICK));
      drain();

      // channels moved after ready; baseline stays
      program_regs(1023, 32767, 127, 2, 0);
      run_random_phase(0, 0);
      program_regs(0, 0, 1, 3, 3);
      run_random_phase(67, 0);
      program_regs($urandom_range(0, 1023), $urandom_range(0, 32767), 64, 0, 1);
      run_random_phase(0, 67);
      program_regs($urandom_range(0, 1023), $urandom_range(0, 32767),
                   $urandom_range(0, 127), $urandom_range(0, 3), $urandom_range(0, 3));
      run_random_phase(8, 8);

      $display("%0d request beats sent, %0d command pairs checked, %0d register writes",
               beats_sent, cmds_checked, reg_writes);
      $display("idling phases: none, sender only, receiver only, both; %0d mismatches",
               mismatches);
      if (mismatches == 0 && expected_cmds.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
